// File: src/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Types, constants and the alphabet lookup shared by the line-wrapping
// base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam int unsigned MAX_LINE_W          = 10;
  localparam int unsigned LINE_COUNT_BITS_DEF = 10;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;
  localparam int unsigned MAX_CHARS           = 6;
  localparam int unsigned LEN_W               = 3;

  localparam logic [MAX_LINE_W-1:0] MAX_LINE_RESET = 10'd76;

  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // place of a byte in its 3-byte group
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
  } out_word_t;

  // characters caused by one byte, first at index 0
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [LEN_W-1:0]          len;
  } char_rec_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// File: src/b64lw_front.sv
// ----------------------------------------------------------------------------
// b64lw_front
// Takes input words, tracks group position, leftover bits and line count,
// and builds the full character list for each byte.
// ----------------------------------------------------------------------------
module b64lw_front #(
  parameter int unsigned LINE_COUNT_BITS = b64lw_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [b64lw_pkg::MAX_LINE_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  b64lw_pkg::in_word_t                   in_data_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output b64lw_pkg::char_rec_t                  push_rec_o
);
  import b64lw_pkg::*;

  localparam int unsigned SUM_W = LINE_COUNT_BITS + 1;
  localparam int unsigned CMP_W = (SUM_W > MAX_LINE_W) ? SUM_W : MAX_LINE_W;

  logic [MAX_LINE_W-1:0]      max_line_q;
  logic [1:0]                 pos_q, pos_d, pos;
  logic [7:0]                 prev_q, prev_d;
  logic [LINE_COUNT_BITS-1:0] count_q, count_d;
  logic [SUM_W-1:0]           sum;
  logic                       wrap;
  logic [LEN_W-1:0]           n;
  logic [MAX_CHARS-1:0][7:0]  chars;
  logic [7:0]                 b;
  logic                       accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign b          = in_data_i.data_byte;

  always_comb begin
    pos   = (pos_q == 2'd3) ? POS_FIRST : pos_q;
    chars = '0;
    n     = '0;
    sum   = {1'b0, count_q};
    pos_d = POS_SECOND;
    case (pos)
      POS_SECOND: begin
        chars[0] = sym({prev_q[1:0], b[7:4]});
        n        = LEN_W'(1);
        sum      = sum + SUM_W'(1);
        pos_d    = POS_THIRD;
      end
      POS_THIRD: begin
        chars[0] = sym({prev_q[3:0], b[7:6]});
        chars[1] = sym(b[5:0]);
        n        = LEN_W'(2);
        sum      = sum + SUM_W'(2);
        pos_d    = POS_FIRST;
      end
      default: begin
        chars[0] = sym(b[7:2]);
        n        = LEN_W'(1);
        sum      = sum + SUM_W'(1);
        pos_d    = POS_SECOND;
      end
    endcase
    prev_d = b;

    wrap = CMP_W'(sum) >= CMP_W'(max_line_q);
    if (wrap) begin
      chars[n]             = CHAR_CR;
      chars[LEN_W'(n + 1)] = CHAR_LF;
      n                    = LEN_W'(n + 2);
      count_d              = '0;
    end else if (sum[SUM_W-1]) begin
      count_d = '1; // saturate
    end else begin
      count_d = sum[LINE_COUNT_BITS-1:0];
    end

    if (in_data_i.end_of_message) begin
      if (pos_d == POS_SECOND) begin
        chars[n]             = sym({b[1:0], 4'b0000});
        chars[LEN_W'(n + 1)] = CHAR_PAD;
        chars[LEN_W'(n + 2)] = CHAR_PAD;
        n                    = LEN_W'(n + 3);
      end else if (pos_d == POS_THIRD) begin
        chars[n]             = sym({b[3:0], 2'b00});
        chars[LEN_W'(n + 1)] = CHAR_PAD;
        n                    = LEN_W'(n + 2);
      end
      pos_d   = POS_FIRST;
      prev_d  = '0;
      count_d = '0;
    end
  end

  assign push_o           = accept;
  assign push_rec_o.chars = chars;
  assign push_rec_o.len   = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_FIRST;
      prev_q     <= '0;
      count_q    <= '0;
      max_line_q <= MAX_LINE_RESET;
    end else begin
      if (cfg_we_i) begin
        max_line_q <= cfg_data_i;
      end
      if (accept) begin
        pos_q   <= pos_d;
        prev_q  <= prev_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// File: src/b64lw_queue.sv
// ----------------------------------------------------------------------------
// b64lw_queue
// Short register queue of character records between front and back.
// ----------------------------------------------------------------------------
module b64lw_queue #(
  parameter int unsigned DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64lw_pkg::char_rec_t push_rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output b64lw_pkg::char_rec_t pop_rec_o
);
  import b64lw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  char_rec_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_rec_o = mem_q[rd_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= inc(wr_q);
      if (do_pop)  rd_q <= inc(rd_q);
      if (do_push && !do_pop) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CNT_W'(cnt_q - 1'b1);
      end
    end
  end

endmodule

// File: src/b64lw_back.sv
// ----------------------------------------------------------------------------
// b64lw_back
// Serialises one record at a time into output words, one character a cycle
// while a record is held and the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module b64lw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  b64lw_pkg::char_rec_t q_rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64lw_pkg::out_word_t out_data_o
);
  import b64lw_pkg::*;

  char_rec_t        rec_q;
  logic [LEN_W-1:0] idx_q;
  logic             busy_q;
  logic             ovalid_q;
  out_word_t        odata_q;
  logic             can_load, emit, last;

  assign can_load = ~ovalid_q | out_ready_i;
  assign emit     = busy_q & can_load;
  assign last     = (idx_q == LEN_W'(rec_q.len - 1'b1));
  // next record loads as the current one hands over its last character
  assign pop_o    = q_valid_i & (~busy_q | (emit & last));

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= q_rec_i;
    end
    if (emit) begin
      odata_q.out_char <= rec_q.chars[idx_q];
      odata_q.run_end  <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        busy_q <= ~last;
        idx_q  <= LEN_W'(idx_q + 1'b1);
      end
    end
  end

endmodule

// File: src/base64_line_wrapping_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_line_wrapping_encoder_top
// Base64 encoder with CR LF line wrapping, one raw byte per input word.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o with a byte and an end-of-message flag.
// Output channel: out_valid_o/out_ready_i, one ASCII character per word;
// run_end marks the last character caused by an input byte.
// cfg_we_i writes the line length (characters before CR LF) from cfg_data_i.
// A byte's first character passes the queue entry written at acceptance, the
// back-end record register, then the output register.
// Throughput: the back end sends one character a cycle while the receiver is
// ready; a byte causes 1 to 6 characters. The front accepts a byte per
// cycle while the two-entry queue has room.
// Reset clears group position, leftover bits, line count and queue, and sets
// the line length to 76. A stalled receiver holds the output word; the queue
// fills and in_ready_o drops once both entries are taken.
// ----------------------------------------------------------------------------
module base64_line_wrapping_encoder_top #(
  parameter int unsigned LINE_COUNT_BITS = b64lw_pkg::LINE_COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH     = b64lw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [b64lw_pkg::MAX_LINE_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  b64lw_pkg::in_word_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output b64lw_pkg::out_word_t             out_data_o
);
  import b64lw_pkg::*;

  logic      push, q_full, q_valid, pop;
  char_rec_t push_rec, pop_rec;

  b64lw_front #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .q_full_i   (q_full),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  b64lw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_rec_o  (pop_rec)
  );

  b64lw_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (q_valid),
    .q_rec_i    (pop_rec),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// File: src/b64lw_checker.sv
// ----------------------------------------------------------------------------
// b64lw_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64lw_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input b64lw_pkg::out_word_t out_data_o
);
  import b64lw_pkg::*;

  logic       in_acc, out_end;
  logic [3:0] open_q;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_end = out_valid_o & out_ready_i & out_data_o.run_end;

  // bytes accepted whose last character has not yet gone out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_end) begin
      open_q <= open_q + 4'd1;
    end else if (out_end && !in_acc) begin
      open_q <= open_q - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_end |-> open_q != 4'd0 || in_acc)
    else $error("run end with no byte outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'd4)
    else $error("more bytes in flight than the pipeline holds");

  a_cr_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.out_char == CHAR_CR
    |-> !out_data_o.run_end ##1 !out_valid_o || out_data_o.out_char == CHAR_LF)
    else $error("CR not followed by LF");

endmodule

bind base64_line_wrapping_encoder_top b64lw_checker u_b64lw_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .out_data_o
);

// File: verif/tb_base64_line_wrapping_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_base64_line_wrapping_encoder_top
// Self-checking bench for the line-wrapping base64 encoder. Bytes are pushed
// through the input channel as short messages. A scoreboard predicts every
// output character (symbols, CR LF, pads and run_end) and compares it in
// order. The line length is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_base64_line_wrapping_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64lw_pkg::*;

  localparam int unsigned LINE_BITS    = LINE_COUNT_BITS_DEF;
  localparam int unsigned QUIET_LIMIT  = 500;
  localparam int unsigned REPORT_LIMIT = 10;

  class b64_line_scoreboard;
    string                      alphabet;
    logic [1:0]                 grp_pos;
    logic [7:0]                 prev_byte;
    int unsigned                line_cnt;
    int unsigned                count_cap;
    logic [MAX_LINE_W-1:0]      line_max;
    out_word_t                  expected_chars[$];
    int unsigned                mismatches;

    function new(int unsigned cnt_bits);
      alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      grp_pos    = POS_FIRST;
      prev_byte  = 8'h00;
      line_cnt   = 0;
      count_cap  = (1 << cnt_bits) - 1;
      line_max   = MAX_LINE_RESET;
      mismatches = 0;
    endfunction

    function logic [7:0] b64_char(logic [5:0] v);
      return alphabet[v];
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    // predicts the characters caused by one accepted byte
    function void note_byte(in_word_t w);
      logic [7:0]  chars[$];
      logic [7:0]  b;
      int unsigned sum;
      out_word_t   ow;
      b   = w.data_byte;
      sum = line_cnt;
      case (grp_pos)
        POS_SECOND: begin
          chars.push_back(b64_char({prev_byte[1:0], b[7:4]}));
          sum += 1;
        end
        POS_THIRD: begin
          chars.push_back(b64_char({prev_byte[3:0], b[7:6]}));
          chars.push_back(b64_char(b[5:0]));
          sum += 2;
        end
        default: begin
          // unused position behaves as the first
          chars.push_back(b64_char(b[7:2]));
          sum += 1;
        end
      endcase
      grp_pos   = (grp_pos == POS_SECOND) ? POS_THIRD :
                  (grp_pos == POS_THIRD)  ? POS_FIRST : POS_SECOND;
      prev_byte = b;
      // compare on the full sum, store saturated
      if (sum >= line_max) begin
        chars.push_back(CHAR_CR);
        chars.push_back(CHAR_LF);
        line_cnt = 0;
      end else begin
        line_cnt = (sum > count_cap) ? count_cap : sum;
      end
      if (w.end_of_message) begin
        if (grp_pos == POS_SECOND) begin
          chars.push_back(b64_char({prev_byte[1:0], 4'b0000}));
          chars.push_back(CHAR_PAD);
          chars.push_back(CHAR_PAD);
        end else if (grp_pos == POS_THIRD) begin
          chars.push_back(b64_char({prev_byte[3:0], 2'b00}));
          chars.push_back(CHAR_PAD);
        end
        grp_pos   = POS_FIRST;
        prev_byte = 8'h00;
        line_cnt  = 0;
      end
      foreach (chars[k]) begin
        ow.out_char = chars[k];
        ow.run_end  = (k == chars.size() - 1);
        expected_chars.push_back(ow);
      end
    endfunction

    function void check_char(out_word_t got);
      out_word_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected word char=%h run_end=%b", $time, got.out_char,
                   got.run_end);
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char || got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch char exp=%h got=%h run_end exp=%b got=%b", $time,
                   want.out_char, got.out_char, want.run_end, got.run_end);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [MAX_LINE_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;

  b64_line_scoreboard sb = new(LINE_BITS);

  bit          src_idle_on   = 1'b0;
  bit          sink_stall_on = 1'b0;
  int unsigned msg_left      = 0;
  int unsigned quiet_cycles  = 0;

  in_word_t directed_words[$] = '{
    '{8'h00, 1'b1},                                   // two pads
    '{8'hFF, 1'b1},
    '{8'hFF, 1'b0}, '{8'hFF, 1'b1},                   // one pad
    '{8'hFB, 1'b0}, '{8'hEF, 1'b0}, '{8'hBE, 1'b1},   // '+' and group end at message end
    '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b1},
    '{8'h4D, 1'b0}, '{8'h61, 1'b0}, '{8'h6E, 1'b1},
    '{8'h80, 1'b1},
    '{8'h55, 1'b0}, '{8'hAA, 1'b1},
    '{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h7F, 1'b1}
  };

  base64_line_wrapping_encoder_top #(
    .LINE_COUNT_BITS(LINE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver with bursty back-pressure
  always begin
    @(negedge clk_i);
    if (sink_stall_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_char(out_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input in_word_t w);
    @(negedge clk_i);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(w);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random messages; a message may run on across phases
  task automatic feed_random(input int unsigned n_words, input int unsigned max_msg,
                             input bit allow_idle);
    in_word_t w;
    src_idle_on   = allow_idle && ($urandom_range(0, 3) != 0);
    sink_stall_on = allow_idle && ($urandom_range(0, 3) != 0);
    repeat (n_words) begin
      if (msg_left == 0) msg_left = $urandom_range(1, max_msg);
      msg_left--;
      w.data_byte      = pick_byte();
      w.end_of_message = (msg_left == 0);
      send_byte(w);
    end
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_line_max(input logic [MAX_LINE_W-1:0] len);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= len;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    sb.line_max = len;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    src_idle_on   = ($urandom_range(0, 1) != 0);
    sink_stall_on = ($urandom_range(0, 1) != 0);
    foreach (directed_words[i]) send_byte(directed_words[i]);

    // first message long enough to wrap at the reset length
    msg_left = $urandom_range(57, 60);
    feed_random(60, 40, 1'b1);

    set_line_max('0);          // CR LF after every byte
    feed_random(15, 8, 1'b1);
    set_line_max('1);
    feed_random(8, 10, 1'b1);
    set_line_max(MAX_LINE_W'($urandom_range(2, 20)));
    feed_random(20, 12, 1'b1);
    set_line_max(MAX_LINE_W'(1));
    feed_random(15, 6, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
